// ===== sv/owbm_pkg.sv =====
// Package for the 1-wire bus master: command codes, bus phase codes,
// timing register indexes and reset values, and the result record type.
// No dependencies; owbm_cfg_regs, owbm_fsm, the top level and the testbench import it.
package owbm_pkg;

	// Item codes on the command channel.
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_RESET = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	// Bus phase codes.
	localparam int unsigned PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RST_LOW  = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RST_WAIT = 4'd2;
	localparam logic [PHASE_W-1:0] PH_RST_TAIL = 4'd3;
	localparam logic [PHASE_W-1:0] PH_W1_LOW   = 4'd4;
	localparam logic [PHASE_W-1:0] PH_W1_REL   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_W0_LOW   = 4'd6;
	localparam logic [PHASE_W-1:0] PH_W0_REL   = 4'd7;
	localparam logic [PHASE_W-1:0] PH_RD_LOW   = 4'd8;
	localparam logic [PHASE_W-1:0] PH_RD_REL   = 4'd9;

	// Timing register file.
	localparam int unsigned NUM_CFG   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 10;

	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_W1_LOW        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_W1_RELEASE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_W0_LOW        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_READ_RELEASE  = 3'd7;

	localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
		10'd480, 10'd80, 10'd400, 10'd1, 10'd60, 10'd60, 10'd2, 10'd60
	};

	// One result record, as produced for every transaction.
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       device_present;
		logic [7:0] read_data;
		logic       rejected;
	} rsp_t;

endpackage

// ===== sv/owbm_cmd_if.sv =====
// Command channel of the 1-wire bus master: valid/ready plus one item
// (tick or command, write byte, sampled line level). No dependencies.
interface owbm_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic       line_level;

	modport source (output valid, action, data_byte, line_level, input ready);
	modport sink (input valid, action, data_byte, line_level, output ready);
endinterface

// ===== sv/owbm_rsp_if.sv =====
// Result channel of the 1-wire bus master: valid/ready plus one result
// record per command transaction. No dependencies.
interface owbm_rsp_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       device_present;
	logic [7:0] read_data;
	logic       rejected;

	modport source (output valid, drive_low, busy_res, done_res, device_present,
		read_data, rejected, input ready);
	modport sink (input valid, drive_low, busy_res, done_res, device_present,
		read_data, rejected, output ready);
endinterface

// ===== sv/owbm_cfg_regs.sv =====
// Timing register file of the 1-wire bus master. Holds the eight phase
// lengths and presents each one clipped to the phase timer width.
// Depends on owbm_pkg.
module owbm_cfg_regs
	import owbm_pkg::*;
#(
	parameter int unsigned TIMER_WIDTH = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata,
	output logic [TIMER_WIDTH-1:0] tload [NUM_CFG]
);

	localparam int unsigned EXT_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam logic [EXT_W-1:0] TIMER_MAX = EXT_W'({TIMER_WIDTH{1'b1}});

	logic [CFG_W-1:0] regs_q [NUM_CFG];

	// Register writes; reset restores the default timings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) regs_q[i] <= CFG_RESET[i];
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_wdata;
		end
	end

	// Saturate each timing to what the phase timer can hold.
	always_comb begin
		for (int i = 0; i < NUM_CFG; i++) begin
			if (EXT_W'(regs_q[i]) > TIMER_MAX) tload[i] = TIMER_MAX[TIMER_WIDTH-1:0];
			else tload[i] = TIMER_WIDTH'(regs_q[i]);
		end
	end

endmodule

// ===== sv/owbm_fsm.sv =====
// Bus phase sequencer of the 1-wire bus master: phase, phase timer, bit
// counter and shift byte, updated once per accepted transaction, with the
// result record computed from the updated state. Depends on owbm_pkg.
module owbm_fsm
	import owbm_pkg::*;
#(
	parameter int unsigned TIMER_WIDTH = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [1:0]             action,
	input  logic [7:0]             data_byte,
	input  logic                   line_level,
	input  logic [TIMER_WIDTH-1:0] tload [NUM_CFG],
	output rsp_t                   result
);

	logic [PHASE_W-1:0]     phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic [2:0]             bit_q, bit_d;
	logic [7:0]             shift_q, shift_d;
	logic                   present_q, present_d;
	logic [7:0]             rbyte_q, rbyte_d;
	logic                   done, rej;

	// Next state for one item: a command start, or one tick of the timer.
	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		present_d = present_q;
		rbyte_d   = rbyte_q;
		done      = 1'b0;
		rej       = 1'b0;

		if (action != ACT_TICK) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				unique case (action)
					ACT_RESET: begin
						phase_d = PH_RST_LOW;
						timer_d = tload[REG_RESET_LOW];
					end
					ACT_WRITE: begin
						shift_d = data_byte;
						bit_d   = 3'd0;
						phase_d = data_byte[0] ? PH_W1_LOW : PH_W0_LOW;
						timer_d = data_byte[0] ? tload[REG_W1_LOW] : tload[REG_W0_LOW];
					end
					default: begin
						shift_d = 8'd0;
						bit_d   = 3'd0;
						phase_d = PH_RD_LOW;
						timer_d = tload[REG_READ_LOW];
					end
				endcase
			end
		end else if (phase_q != PH_IDLE) begin
			if (timer_q > TIMER_WIDTH'(1)) begin
				timer_d = timer_q - TIMER_WIDTH'(1);
			end else begin
				// The current phase ends; the next one starts on this tick.
				unique case (phase_q)
					PH_RST_LOW: begin
						phase_d = PH_RST_WAIT;
						timer_d = tload[REG_PRESENCE_WAIT];
					end
					PH_RST_WAIT: begin
						present_d = ~line_level;
						phase_d   = PH_RST_TAIL;
						timer_d   = tload[REG_RESET_TAIL];
					end
					PH_RST_TAIL: begin
						phase_d = PH_IDLE;
						done    = 1'b1;
					end
					PH_W1_LOW: begin
						phase_d = PH_W1_REL;
						timer_d = tload[REG_W1_RELEASE];
					end
					PH_W0_LOW: begin
						phase_d = PH_W0_REL;
						timer_d = TIMER_WIDTH'(1);
					end
					PH_W1_REL, PH_W0_REL: begin
						if (bit_q == 3'd7) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							bit_d   = bit_q + 3'd1;
							shift_d = {1'b0, shift_q[7:1]};
							phase_d = shift_q[1] ? PH_W1_LOW : PH_W0_LOW;
							timer_d = shift_q[1] ? tload[REG_W1_LOW] : tload[REG_W0_LOW];
						end
					end
					PH_RD_LOW: begin
						shift_d = shift_q | (8'(line_level) << bit_q);
						phase_d = PH_RD_REL;
						timer_d = tload[REG_READ_RELEASE];
					end
					PH_RD_REL: begin
						if (bit_q == 3'd7) begin
							rbyte_d = shift_q;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = PH_RD_LOW;
							timer_d = tload[REG_READ_LOW];
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// Result record, taken from the state after this item.
	always_comb begin
		result.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_W1_LOW) ||
			(phase_d == PH_W0_LOW) || (phase_d == PH_RD_LOW);
		result.busy_res       = (phase_d != PH_IDLE);
		result.done_res       = done;
		result.device_present = present_d;
		result.read_data      = rbyte_d;
		result.rejected       = rej;
	end

	// State registers advance only on an accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			bit_q     <= 3'd0;
			shift_q   <= 8'd0;
			present_q <= 1'b0;
			rbyte_q   <= 8'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			bit_q     <= bit_d;
			shift_q   <= shift_d;
			present_q <= present_d;
			rbyte_q   <= rbyte_d;
		end
	end

endmodule

// ===== sv/onewire_bus_master_core.sv =====
// Top level of the 1-wire bus master: timing registers, phase sequencer
// and the result register. Depends on owbm_pkg, owbm_cmd_if, owbm_rsp_if,
// owbm_cfg_regs and owbm_fsm.
//
// Each item on cmd is either a one-microsecond tick or a command (bus
// reset, write byte, read byte), given with the sampled line level. The
// block takes one transaction per clock cycle: cmd stays ready while a
// result waits, as long as that result is taken in the same cycle. It
// returns exactly one result per transaction on rsp in the cycle after
// acceptance: the whole step is a single pass through the phase
// sequencer into the state and result registers. Timing registers are
// 10 bits, written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while the block is idle (not enforced). Values above
// the TIMER_WIDTH range saturate and a value of zero acts as one tick.
module onewire_bus_master_core
	import owbm_pkg::*;
#(
	parameter int unsigned TIMER_WIDTH = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	owbm_cmd_if.sink             cmd,
	owbm_rsp_if.source           rsp
);

	logic [TIMER_WIDTH-1:0] tload [NUM_CFG];
	logic                   accept;
	rsp_t                   result;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	// A new transaction may enter whenever the result slot is free or drains.
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	owbm_cfg_regs #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tload     (tload)
	);

	owbm_fsm #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.action     (cmd.action),
		.data_byte  (cmd.data_byte),
		.line_level (cmd.line_level),
		.tload      (tload),
		.result     (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) rsp_q <= result;
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.drive_low      = rsp_q.drive_low;
	assign rsp.busy_res       = rsp_q.busy_res;
	assign rsp.done_res       = rsp_q.done_res;
	assign rsp.device_present = rsp_q.device_present;
	assign rsp.read_data      = rsp_q.read_data;
	assign rsp.rejected       = rsp_q.rejected;

	// A rejected command leaves a command in progress.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.rejected |-> rsp_q.busy_res)
		else $error("rejected result without a command in progress");

	// A finishing command leaves the bus idle and released.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.done_res |-> !rsp_q.busy_res && !rsp_q.drive_low)
		else $error("done result while still busy or driving");

	// The line is only pulled low during a command.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.drive_low |-> rsp_q.busy_res)
		else $error("line driven low while idle");

	// Every accepted transaction shows up as a pending result next cycle.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted transaction produced no result");

endmodule

// ===== tb/onewire_bus_master_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 1-wire bus master core: a directed table, then random
// ticks and commands under several timing register sets. Depends on owbm_pkg, the interfaces and the core.
module onewire_bus_master_core_tb;
	import owbm_pkg::*;

	localparam int STALL_LIMIT = 4000;

	typedef enum {DIR_ITEM, DIR_ZERO_CFG} dir_kind_t;
	typedef enum {SET_SMALL, SET_EDGE, SET_MID} cfg_mode_t;

	typedef struct {
		dir_kind_t  kind;
		logic [1:0] act;
		logic [7:0] data;
		logic       line;
		int         reps;
		bit         typed;
		rsp_t       want;
	} dir_row_t;

	typedef struct {
		cfg_mode_t mode;
		int        items;
		int        calm_lo;
		int        calm_hi;
	} plan_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	owbm_cmd_if cmd_ch ();
	owbm_rsp_if rsp_ch ();

	onewire_bus_master_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	// Predicted bus state and timing registers.
	logic [PHASE_W-1:0] bus_ph;
	logic [CFG_W-1:0]   bus_tmr;
	logic [2:0]         bus_bit;
	logic [7:0]         bus_shift;
	logic               bus_present;
	logic [7:0]         bus_rd;
	logic [CFG_W-1:0]   cfg_shadow [NUM_CFG];

	rsp_t due_status [$];
	bit   row_typed;
	rsp_t row_want;
	bit   calm;
	int   errors;
	int   stall_cycles;
	int   n_items;
	int   n_started;
	int   n_rejected;
	int   n_done;

	// Directed table. Rows with a typed status are checked against it instead of the prediction.
	dir_row_t dir_tab [25] = '{
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{DIR_ITEM, ACT_READ,  8'h00, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
		'{DIR_ITEM, ACT_WRITE, 8'hFF, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
		'{DIR_ITEM, ACT_RESET, 8'h00, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
		'{DIR_ITEM, ACT_READ,  8'h00, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
		'{DIR_ZERO_CFG, ACT_TICK, 8'h00, 1'b0, 0, 1'b0, '0},
		'{DIR_ITEM, ACT_READ,  8'h00, 1'b1, 1, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b1, 15, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, 1'b0}},
		'{DIR_ITEM, ACT_READ,  8'h00, 1'b0, 1, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b0, 15, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b0, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
		'{DIR_ITEM, ACT_RESET, 8'h00, 1'b1, 1, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b1, 1, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b0, 1, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0}},
		'{DIR_ITEM, ACT_WRITE, 8'h00, 1'b1, 1, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b1, 16, 1'b0, '0},
		'{DIR_ITEM, ACT_WRITE, 8'hFF, 1'b1, 1, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b1, 16, 1'b0, '0},
		'{DIR_ITEM, ACT_RESET, 8'h00, 1'b1, 1, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b1, 2, 1'b0, '0},
		'{DIR_ITEM, ACT_TICK,  8'h00, 1'b1, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
		'{DIR_ITEM, ACT_WRITE, 8'hA5, 1'b1, 1, 1'b0, '0},
		'{DIR_ITEM, ACT_READ,  8'h00, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}}
	};

	// Random phases: timing register set, transaction count, window without idling.
	plan_t plan [3] = '{
		'{SET_SMALL, 140, 30, 100},
		'{SET_EDGE, 90, 0, 0},
		'{SET_MID, 100, 0, 0}
	};

	// Load a phase and its timer. TIMER_WIDTH equals the register width, so no saturation.
	function automatic void enter_phase(logic [PHASE_W-1:0] ph, logic [CFG_IDX_W-1:0] idx);
		bus_ph = ph;
		bus_tmr = cfg_shadow[idx];
	endfunction

	function automatic void start_slot();
		if (bus_shift[0]) begin
			enter_phase(PH_W1_LOW, REG_W1_LOW);
		end else begin
			enter_phase(PH_W0_LOW, REG_W0_LOW);
		end
	endfunction

	// Advance the predicted bus by one transaction and return the expected status.
	function automatic rsp_t bus_step(logic [1:0] act, logic [7:0] data, logic line);
		rsp_t r;
		logic fin;
		logic rej;
		fin = 1'b0;
		rej = 1'b0;
		if (act != ACT_TICK) begin
			if (bus_ph != PH_IDLE) begin
				rej = 1'b1;
			end else if (act == ACT_RESET) begin
				enter_phase(PH_RST_LOW, REG_RESET_LOW);
			end else if (act == ACT_WRITE) begin
				bus_shift = data;
				bus_bit = '0;
				start_slot();
			end else begin
				bus_shift = '0;
				bus_bit = '0;
				enter_phase(PH_RD_LOW, REG_READ_LOW);
			end
		end else if (bus_ph != PH_IDLE) begin
			// A phase ends on the tick that finds its timer at one or zero.
			if (bus_tmr <= 1) begin
				case (bus_ph)
					PH_RST_LOW: enter_phase(PH_RST_WAIT, REG_PRESENCE_WAIT);
					PH_RST_WAIT: begin
						bus_present = ~line;
						enter_phase(PH_RST_TAIL, REG_RESET_TAIL);
					end
					PH_RST_TAIL: begin
						bus_ph = PH_IDLE;
						fin = 1'b1;
					end
					PH_W1_LOW: enter_phase(PH_W1_REL, REG_W1_RELEASE);
					PH_W0_LOW: begin
						bus_ph = PH_W0_REL;
						bus_tmr = CFG_W'(1);
					end
					PH_W1_REL, PH_W0_REL: begin
						if (bus_bit == 3'd7) begin
							bus_ph = PH_IDLE;
							fin = 1'b1;
						end else begin
							bus_bit++;
							bus_shift = bus_shift >> 1;
							start_slot();
						end
					end
					PH_RD_LOW: begin
						bus_shift[bus_bit] = line;
						enter_phase(PH_RD_REL, REG_READ_RELEASE);
					end
					PH_RD_REL: begin
						if (bus_bit == 3'd7) begin
							bus_rd = bus_shift;
							bus_ph = PH_IDLE;
							fin = 1'b1;
						end else begin
							bus_bit++;
							enter_phase(PH_RD_LOW, REG_READ_LOW);
						end
					end
					default: bus_ph = PH_IDLE;
				endcase
			end else begin
				bus_tmr--;
			end
		end
		r.drive_low = bus_ph inside {PH_RST_LOW, PH_W1_LOW, PH_W0_LOW, PH_RD_LOW};
		r.busy_res = (bus_ph != PH_IDLE);
		r.done_res = fin;
		r.device_present = bus_present;
		r.read_data = bus_rd;
		r.rejected = rej;
		return r;
	endfunction

	function automatic logic [CFG_W-1:0] cfg_value(cfg_mode_t mode, int unsigned idx);
		case (mode)
			SET_SMALL: return CFG_W'($urandom_range(0, 3));
			SET_EDGE: return CFG_W'($urandom_range(0, 1));
			default: return CFG_W'($urandom_range(0, 12));
		endcase
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Present one transaction at a falling edge and hold it until accepted.
	task automatic send_item(logic [1:0] act, logic [7:0] data, logic line, bit typed,
			rsp_t want);
		while (!calm && $urandom_range(0, 99) < 36) begin
			cmd_ch.valid = 1'b0;
			cmd_ch.action = 2'($urandom);
			cmd_ch.data_byte = 8'($urandom);
			cmd_ch.line_level = 1'($urandom);
			@(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.action = act;
		cmd_ch.data_byte = data;
		cmd_ch.line_level = line;
		row_typed = typed;
		row_want = want;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// Tick until the bus is idle, then let every status arrive.
	task automatic settle_bus();
		while (bus_ph != PH_IDLE) begin
			send_item(ACT_TICK, 8'($urandom), 1'($urandom), 1'b0, '0);
		end
		cmd_ch.valid = 1'b0;
		row_typed = 1'b0;
		while (due_status.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(int unsigned idx, logic [CFG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = CFG_IDX_W'(idx);
		cfg_wdata = val;
		cfg_shadow[idx] = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Mostly commands when idle, mostly ticks when busy, with some rejected commands.
	task automatic run_random(int count, int calm_lo, int calm_hi);
		logic [1:0] act;
		int r;
		for (int n = 0; n < count; n++) begin
			calm = (n >= calm_lo) && (n < calm_hi);
			r = $urandom_range(0, 99);
			if (bus_ph == PH_IDLE) begin
				act = (r < 65) ? 2'($urandom_range(ACT_RESET, ACT_READ)) : ACT_TICK;
			end else begin
				act = (r < 8) ? 2'($urandom_range(ACT_RESET, ACT_READ)) : ACT_TICK;
			end
			send_item(act, 8'($urandom), 1'($urandom), 1'b0, '0);
		end
		calm = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side ready, with random stalls outside the calm window.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = calm || ($urandom_range(0, 99) >= 36);
		end
	end

	// Predict every accepted command transaction.
	always @(posedge clk) begin
		rsp_t p;
		if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
			p = bus_step(cmd_ch.action, cmd_ch.data_byte, cmd_ch.line_level);
			due_status.push_back(row_typed ? row_want : p);
			n_items++;
			if (p.rejected) n_rejected++;
			else if (cmd_ch.action != ACT_TICK) n_started++;
			if (p.done_res) n_done++;
		end
	end

	// Compare every accepted status transaction with the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (due_status.size() == 0) begin
				$error("status transaction with no command pending");
				errors++;
			end else begin
				want = due_status.pop_front();
				check_field("drive_low", 8'(want.drive_low), 8'(rsp_ch.drive_low));
				check_field("busy_res", 8'(want.busy_res), 8'(rsp_ch.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(rsp_ch.done_res));
				check_field("device_present", 8'(want.device_present),
					8'(rsp_ch.device_present));
				check_field("read_data", want.read_data, rsp_ch.read_data);
				check_field("rejected", 8'(want.rejected), 8'(rsp_ch.rejected));
			end
		end
	end

	// Count cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		do @(posedge clk); while (stall_cycles < STALL_LIMIT);
		$display("onewire_bus_master_core regression: fail");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, final check.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ACT_TICK;
		cmd_ch.data_byte = '0;
		cmd_ch.line_level = 1'b1;
		row_typed = 1'b0;
		row_want = '0;
		calm = 1'b0;
		errors = 0;
		stall_cycles = 0;
		n_items = 0;
		n_started = 0;
		n_rejected = 0;
		n_done = 0;
		for (int k = 0; k < NUM_CFG; k++) cfg_shadow[k] = CFG_RESET[k];
		bus_ph = PH_IDLE;
		bus_tmr = '0;
		bus_bit = '0;
		bus_shift = '0;
		bus_present = 1'b0;
		bus_rd = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: reset values first, then every register at zero.
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == DIR_ZERO_CFG) begin
				settle_bus();
				for (int k = 0; k < NUM_CFG; k++) write_reg(k, '0);
			end else begin
				repeat (dir_tab[i].reps) begin
					send_item(dir_tab[i].act, dir_tab[i].data, dir_tab[i].line,
						dir_tab[i].typed, dir_tab[i].want);
				end
			end
		end
		settle_bus();

		// Random part, one timing register set per phase.
		foreach (plan[p]) begin
			for (int k = 0; k < NUM_CFG; k++) write_reg(k, cfg_value(plan[p].mode, k));
			run_random(plan[p].items, plan[p].calm_lo, plan[p].calm_hi);
			settle_bus();
		end

		$display("Checked %0d transactions: %0d commands started, %0d rejected, %0d finished.",
			n_items, n_started, n_rejected, n_done);
		$display("Timing sets: reset values, all zero, small, zero/one, mid range.");
		if (errors == 0 && due_status.size() == 0) begin
			$display("onewire_bus_master_core regression: pass");
		end else begin
			$display("onewire_bus_master_core regression: fail");
		end
		$finish;
	end

endmodule
